[src/lspe_pkg.sv]
// Shared types and constants of the LED strip pulse encoder.
package lspe_pkg;

   localparam int BITS_PER_COLOUR = 8;
   localparam int BIT_CNT_W       = $clog2(BITS_PER_COLOUR);

   localparam int DIV_W     = 13;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   localparam int SLOT_W       = 18;
   localparam int PULSE_SLOT_W = 14;

   localparam int LED_COUNT_W = 12;
   localparam int GROUP_W     = 12;
   localparam int COLOURS_W   = 3;
   localparam int INDEX_W     = 9;
   localparam int CHANNEL_W   = 13;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LED_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOURS   = 2'd2;

   localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST = 12'd8;
   localparam logic [GROUP_W-1:0]     GROUP_RST     = 12'd1;
   localparam logic [COLOURS_W-1:0]   COLOURS_RST   = 3'd3;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   localparam logic [1:0] CODE_ZERO = 2'd1;
   localparam logic [1:0] CODE_ONE  = 2'd2;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_rsp_type;

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_WRITE_MOD = 8'b0000_0010,
      S_COLOUR    = 8'b0000_0100,
      S_GROUP     = 8'b0000_1000,
      S_RESOLVE   = 8'b0001_0000,
      S_MOD       = 8'b0010_0000,
      S_READ      = 8'b0100_0000,
      S_EMIT      = 8'b1000_0000
   } state_type;

endpackage

[src/led_strip_pulse_encoder.sv]
// Top level of the LED strip pulse encoder: sequencer, registers and store.
//
// Usage:
//  - Input channel: drive start high with req_* for one cycle while busy is
//    low; that edge is the transfer. req_op = 0 writes req_store_value into
//    the store at req_store_index; req_op = 1 renders req_channel.
//  - Result channel: a render of an in-range channel gives eight duty codes,
//    MSB first, on consecutive cycles, each marked by rsp_strobe; rsp_last
//    flags the eighth. The receiver cannot stall: every strobed cycle is a
//    transfer.
//  - Sequence: a store write goes straight into the store, or first through
//    the divider for index % STORE_DEPTH when STORE_DEPTH is not a power
//    of two. A render makes one divider pass for the colour, one more when
//    group_size exceeds one and one more when STORE_DEPTH is not a power of
//    two, on the shared one-bit-per-cycle divider. Out-of-range renders give nothing.
//  - Reset: registers return to 8 LEDs, group 1, 3 colours; the store is
//    then swept to zero with busy held high. APB writes are taken throughout.
module led_strip_pulse_encoder
   import lspe_pkg::*;
#(
   parameter int STORE_DEPTH   = 512,
   parameter int LEAD_IN_SLOTS = 80,
   parameter int MAX_PULSES    = 8192
)
(
   input  logic                    clock,
   input  logic                    reset,
   // input channel
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_op,
   input  logic [INDEX_W-1:0]      req_store_index,
   input  logic [BITS_PER_COLOUR-1:0] req_store_value,
   input  logic [CHANNEL_W-1:0]    req_channel,
   // result channel
   output logic                    rsp_strobe,
   output logic [PULSE_SLOT_W-1:0] rsp_pulse_slot,
   output logic [1:0]              rsp_pulse_code,
   output logic                    rsp_slot_overflow,
   output logic                    rsp_last,
   // APB register port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   localparam int  ADDR_W        = $clog2(STORE_DEPTH);
   localparam bit  DEPTH_IS_POW2 = ((STORE_DEPTH & (STORE_DEPTH - 1)) == 0);
   localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(LEAD_IN_SLOTS + MAX_PULSES);
   localparam logic [SLOT_W-1:0] SLOT_LEAD  = SLOT_W'(LEAD_IN_SLOTS);
   localparam logic [DIV_W-1:0]  DEPTH_DVS  = DIV_W'(STORE_DEPTH);

   // configuration registers
   logic [LED_COUNT_W-1:0] led_count_ff, led_count_in;
   logic [GROUP_W-1:0]     group_ff, group_in;
   logic [COLOURS_W-1:0]   colours_ff, colours_in;
   logic                   csr_wr;

   // sequencer
   state_type                  state_ff, state_in;
   logic [CHANNEL_W-1:0]       ch_ff, ch_in;
   logic [COLOURS_W-1:0]       colour_ff, colour_in;
   logic [DIV_W-1:0]           addr_ff, addr_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic [BITS_PER_COLOUR-1:0] datum_ff, datum_in;
   logic [BITS_PER_COLOUR-1:0] value_ff, value_in;
   logic [BIT_CNT_W-1:0]       bit_ff, bit_in;

   logic                        accept;
   logic [LED_COUNT_W+COLOURS_W-1:0] range_lim;
   logic                        in_range;
   logic [DIV_W-1:0]            index_ext;
   logic [DIV_W-1:0]            colours_ext;
   logic [DIV_W-1:0]            group_prod;

   // shared divider and store
   div_req_type                div_req;
   div_rsp_type                div_rsp;
   logic                       wr_en, rd_en, clearing;
   logic [ADDR_W-1:0]          wr_addr, rd_addr;
   logic [BITS_PER_COLOUR-1:0] wr_data, rd_data;

   lspe_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   lspe_store #(.STORE_DEPTH(STORE_DEPTH)) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

   // ---------------------------------------------------------------------
   // APB registers: pready held high, written on the access phase.
   // ---------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_comb begin
      led_count_in = led_count_ff;
      group_in     = group_ff;
      colours_in   = colours_ff;
      if (csr_wr) begin
         case (paddr[CSR_ADDR_W-1:2])
            CSR_LED_COUNT: led_count_in = pwdata[LED_COUNT_W-1:0];
            CSR_GROUP:     group_in     = pwdata[GROUP_W-1:0];
            CSR_COLOURS:   colours_in   = pwdata[COLOURS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[CSR_ADDR_W-1:2])
         CSR_LED_COUNT: prdata = CSR_DATA_W'(led_count_ff);
         CSR_GROUP:     prdata = CSR_DATA_W'(group_ff);
         CSR_COLOURS:   prdata = CSR_DATA_W'(colours_ff);
         default:       prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer. The divider is reused for channel / colours (colour and
   // LED), LED / group_size (group) and address % STORE_DEPTH when the
   // depth is not a power of two.
   // ---------------------------------------------------------------------
   assign busy   = (state_ff != S_IDLE) | clearing;
   assign accept = start & ~busy;

   assign range_lim   = (LED_COUNT_W+COLOURS_W)'(led_count_ff) *
                        (LED_COUNT_W+COLOURS_W)'(colours_ff);
   assign in_range    = (colours_ff != '0) &&
                        ((LED_COUNT_W+COLOURS_W)'(req_channel) < range_lim);
   assign index_ext   = DIV_W'(req_store_index);
   assign colours_ext = DIV_W'(colours_ff);
   assign group_prod  = DIV_W'(div_rsp.quotient * colours_ext);

   always_comb begin
      state_in  = state_ff;
      ch_in     = ch_ff;
      colour_in = colour_ff;
      addr_in   = addr_ff;
      slot_in   = slot_ff;
      datum_in  = datum_ff;
      value_in  = value_ff;
      bit_in    = bit_ff;
      div_req   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_en     = 1'b0;
      rd_addr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_WRITE) begin
                  value_in = req_store_value;
                  if (DEPTH_IS_POW2) begin
                     wr_en   = 1'b1;
                     wr_addr = index_ext[ADDR_W-1:0];
                     wr_data = req_store_value;
                  end else begin
                     div_req.start    = 1'b1;
                     div_req.dividend = index_ext;
                     div_req.divisor  = DEPTH_DVS;
                     state_in         = S_WRITE_MOD;
                  end
               end else if (in_range) begin
                  ch_in   = req_channel;
                  slot_in = SLOT_LEAD + {{(SLOT_W-CHANNEL_W-BIT_CNT_W){1'b0}},
                                         req_channel, {BIT_CNT_W{1'b0}}};
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_W'(req_channel);
                  div_req.divisor  = colours_ext;
                  state_in         = S_COLOUR;
               end
            end
         end

         S_WRITE_MOD: begin
            if (div_rsp.done) begin
               wr_en    = 1'b1;
               wr_addr  = div_rsp.remainder[ADDR_W-1:0];
               wr_data  = value_ff;
               state_in = S_IDLE;
            end
         end

         S_COLOUR: begin
            if (div_rsp.done) begin
               colour_in = div_rsp.remainder[COLOURS_W-1:0];
               // red/green swap: colour 0 one byte later, colour 1 one earlier
               if (div_rsp.remainder == '0) begin
                  slot_in = slot_ff + SLOT_W'(BITS_PER_COLOUR);
               end else if (div_rsp.remainder == DIV_W'(1)) begin
                  slot_in = slot_ff - SLOT_W'(BITS_PER_COLOUR);
               end
               if (group_ff <= GROUP_W'(1)) begin
                  addr_in  = DIV_W'(ch_ff);
                  state_in = S_RESOLVE;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = div_rsp.quotient;
                  div_req.divisor  = DIV_W'(group_ff);
                  state_in         = S_GROUP;
               end
            end
         end

         S_GROUP: begin
            if (div_rsp.done) begin
               addr_in  = DIV_W'(colour_ff) + group_prod;
               state_in = S_RESOLVE;
            end
         end

         S_RESOLVE: begin
            if (DEPTH_IS_POW2) begin
               rd_en    = 1'b1;
               rd_addr  = addr_ff[ADDR_W-1:0];
               state_in = S_READ;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = addr_ff;
               div_req.divisor  = DEPTH_DVS;
               state_in         = S_MOD;
            end
         end

         S_MOD: begin
            if (div_rsp.done) begin
               rd_en    = 1'b1;
               rd_addr  = div_rsp.remainder[ADDR_W-1:0];
               state_in = S_READ;
            end
         end

         S_READ: begin
            datum_in = rd_data;
            bit_in   = '0;
            state_in = S_EMIT;
         end

         S_EMIT: begin
            datum_in = {datum_ff[BITS_PER_COLOUR-2:0], 1'b0};
            slot_in  = slot_ff + 1'b1;
            bit_in   = bit_ff + 1'b1;
            if (bit_ff == BIT_CNT_W'(BITS_PER_COLOUR - 1)) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bit_ff       <= '0;
         led_count_ff <= LED_COUNT_RST;
         group_ff     <= GROUP_RST;
         colours_ff   <= COLOURS_RST;
      end else begin
         state_ff     <= state_in;
         bit_ff       <= bit_in;
         led_count_ff <= led_count_in;
         group_ff     <= group_in;
         colours_ff   <= colours_in;
      end
      ch_ff     <= ch_in;
      colour_ff <= colour_in;
      addr_ff   <= addr_in;
      slot_ff   <= slot_in;
      datum_ff  <= datum_in;
      value_ff  <= value_in;
   end

   // result ports straight from the emit registers
   assign rsp_strobe        = (state_ff == S_EMIT);
   assign rsp_pulse_slot    = slot_ff[PULSE_SLOT_W-1:0];
   assign rsp_pulse_code    = datum_ff[BITS_PER_COLOUR-1] ? CODE_ONE : CODE_ZERO;
   assign rsp_slot_overflow = (slot_ff >= SLOT_LIMIT);
   assign rsp_last          = (bit_ff == BIT_CNT_W'(BITS_PER_COLOUR - 1));

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("result strobe continued past the last code");

   a_slot_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe &&
      (rsp_pulse_slot == PULSE_SLOT_W'($past(rsp_pulse_slot) + 1'b1)))
      else $error("codes of one channel not on consecutive slots");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_WRITE_MOD || state_ff == S_COLOUR ||
                        state_ff == S_GROUP || state_ff == S_MOD))
      else $error("divider finished with no state waiting on it");

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy && !clearing)
      else $error("codes emitted while idle or clearing");

endmodule

[src/lspe_div.sv]
// Shared restoring divider, one quotient bit per cycle.
module lspe_div
   import lspe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_W:0]       trial;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      fits    = (trial >= {1'b0, dvs_ff});
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = DIV_CNT_W'(DIV_W);
         rem_in = '0;
         quo_in = div_req.dividend;
         dvs_in = div_req.divisor;
      end else if (run_ff) begin
         rem_in = fits ? DIV_W'(trial - {1'b0, dvs_ff}) : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[src/lspe_store.sv]
// Channel byte store with a clearing sweep after reset.
module lspe_store
   import lspe_pkg::*;
#(
   parameter int STORE_DEPTH = 512
)
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [$clog2(STORE_DEPTH)-1:0]   wr_addr,
   input  logic [BITS_PER_COLOUR-1:0]       wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(STORE_DEPTH)-1:0]   rd_addr,
   output logic [BITS_PER_COLOUR-1:0]       rd_data,
   output logic                             clearing
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);

   logic [BITS_PER_COLOUR-1:0] mem [STORE_DEPTH];
   logic [BITS_PER_COLOUR-1:0] rd_data_ff;
   logic                       clr_ff, clr_in;
   logic [ADDR_W-1:0]          clr_ptr_ff, clr_ptr_in;

   always_comb begin
      clr_in     = clr_ff;
      clr_ptr_in = clr_ptr_ff;
      if (clr_ff) begin
         clr_ptr_in = clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_ptr_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_ptr_ff <= clr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_ptr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_ff;

endmodule

[test/led_strip_pulse_encoder_test.sv]
// Self-checking testbench for the LED strip pulse encoder: store writes, renders, registers.
`timescale 1ns / 1ps

module led_strip_pulse_encoder_test;
   import lspe_pkg::*;

   localparam int STORE_DEPTH    = 512;
   localparam int LEAD_IN_SLOTS  = 80;
   localparam int MAX_PULSES     = 8192;
   localparam int IDLE_PERCENT   = 21;
   // Cycles with no transfer of any kind before the run is declared hung.
   // Covers the post-reset store sweep several times over.
   localparam int WATCHDOG_LIMIT = 4000;
   // Settle time after the last expected code, longer than the longest render.
   localparam int DRAIN_CYCLES   = 60;
   localparam int SHOW_LIMIT     = 10;
   localparam int NUM_PHASES     = 8;

   // One input transfer as seen on the req_ ports.
   typedef struct packed {
      logic                       op;
      logic [INDEX_W-1:0]         index;
      logic [BITS_PER_COLOUR-1:0] value;
      logic [CHANNEL_W-1:0]       channel;
   } led_cmd_type;

   // One duty code as seen on the rsp_ ports.
   typedef struct packed {
      logic [PULSE_SLOT_W-1:0] slot;
      logic [1:0]              code;
      logic                    overflow;
      logic                    last;
   } pulse_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_op = OP_WRITE;
   logic [INDEX_W-1:0]         req_store_index = '0;
   logic [BITS_PER_COLOUR-1:0] req_store_value = '0;
   logic [CHANNEL_W-1:0]       req_channel = '0;
   logic                       rsp_strobe;
   logic [PULSE_SLOT_W-1:0]    rsp_pulse_slot;
   logic [1:0]                 rsp_pulse_code;
   logic                       rsp_slot_overflow;
   logic                       rsp_last;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      paddr = '0;
   logic [CSR_DATA_W-1:0]      pwdata = '0;
   logic [CSR_DATA_W-1:0]      prdata;
   logic                       pready;

   // Shadow of the block: store image and register values.
   logic [BITS_PER_COLOUR-1:0] store_img [STORE_DEPTH];
   int unsigned                cfg_leds    = 32'(LED_COUNT_RST);
   int unsigned                cfg_group   = 32'(GROUP_RST);
   int unsigned                cfg_colours = 32'(COLOURS_RST);

   led_cmd_type cmd_pending [$];   // commands not yet transferred
   pulse_type   pulse_due [$];     // duty codes predicted, not yet seen
   led_cmd_type cmd_on_bus;        // command currently driven on req_
   bit          quiet_mode = 1'b0; // no idling on the request side
   int          mismatches = 0;
   int          stall_cycles = 0;

   // Register settings per phase: LEDs, group size, colours, random commands.
   int phase_leds    [NUM_PHASES] = '{2048, 100, 0, 4095, 2048, 300, 50,  8};
   int phase_group   [NUM_PHASES] = '{   1,   5, 1, 2048,    0,  12,  3,  1};
   int phase_colours [NUM_PHASES] = '{   4,   3, 3,    7,    1,   0,  2,  3};
   int phase_cmds    [NUM_PHASES] = '{  55,  55, 10,  55,   55,  10, 55, 55};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   led_strip_pulse_encoder dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_store_index   (req_store_index),
      .req_store_value   (req_store_value),
      .req_channel       (req_channel),
      .rsp_strobe        (rsp_strobe),
      .rsp_pulse_slot    (rsp_pulse_slot),
      .rsp_pulse_code    (rsp_pulse_code),
      .rsp_slot_overflow (rsp_slot_overflow),
      .rsp_last          (rsp_last),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // Applies one accepted command to the shadow and queues the duty codes
   // it must produce.
   task automatic encode_command(input led_cmd_type cmd);
      int unsigned ch;
      int unsigned colour;
      int unsigned slot;
      int unsigned addr;
      int unsigned s;
      logic [BITS_PER_COLOUR-1:0] datum;
      pulse_type p;
      if (cmd.op == OP_WRITE) begin
         store_img[cmd.index % STORE_DEPTH] = cmd.value;
         return;
      end
      ch = 32'(cmd.channel);
      // zero colours or channel past the strip: nothing comes out
      if (cfg_colours == 0 || ch >= cfg_leds * cfg_colours)
         return;
      colour = ch % cfg_colours;
      slot = LEAD_IN_SLOTS + BITS_PER_COLOUR * ch;
      // red/green swap: colour 0 one byte later, colour 1 one byte earlier
      if (colour == 0)
         slot = slot + BITS_PER_COLOUR;
      else if (colour == 1)
         slot = slot - BITS_PER_COLOUR;
      if (cfg_group <= 1)
         addr = ch;
      else
         addr = colour + ((ch / cfg_colours) / cfg_group) * cfg_colours;
      datum = store_img[addr % STORE_DEPTH];
      for (int b = 0; b < BITS_PER_COLOUR; b++) begin
         s = slot + b;
         p.slot     = s[PULSE_SLOT_W-1:0];
         p.code     = datum[BITS_PER_COLOUR-1-b] ? CODE_ONE : CODE_ZERO;
         p.overflow = (s >= LEAD_IN_SLOTS + MAX_PULSES);
         p.last     = (b == BITS_PER_COLOUR - 1);
         pulse_due.push_back(p);
      end
   endtask

   task automatic note_mismatch(input string what, input pulse_type want, input pulse_type got);
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
         $display("%0t mismatch (%s): expected slot %0d code %0d ovf %0b last %0b,",
                  $realtime, what, want.slot, want.code, want.overflow, want.last,
                  " got slot %0d code %0d ovf %0b last %0b",
                  got.slot, got.code, got.overflow, got.last);
   endtask

   // Request driver: start stays high until the edge where busy is low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            encode_command(cmd_on_bus);
         if (!start || !busy) begin
            if (cmd_pending.size() > 0 &&
                (quiet_mode || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               cmd_on_bus = cmd_pending.pop_front();
               start           <= 1'b1;
               req_op          <= cmd_on_bus.op;
               req_store_index <= cmd_on_bus.index;
               req_store_value <= cmd_on_bus.value;
               req_channel     <= cmd_on_bus.channel;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor: every strobed cycle is a transfer.
   always @(posedge clock) begin
      pulse_type got;
      pulse_type want;
      if (!reset && rsp_strobe) begin
         got = '{rsp_pulse_slot, rsp_pulse_code, rsp_slot_overflow, rsp_last};
         if (pulse_due.size() == 0) begin
            note_mismatch("no code expected", '0, got);
         end else begin
            want = pulse_due.pop_front();
            if (got.slot !== want.slot || got.code !== want.code ||
                got.overflow !== want.overflow || got.last !== want.last)
               note_mismatch("field", want, got);
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (psel && penable))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic add_cmd(input logic op, input int index, input int value, input int channel);
      led_cmd_type c;
      c.op      = op;
      c.index   = INDEX_W'(index);
      c.value   = BITS_PER_COLOUR'(value);
      c.channel = CHANNEL_W'(channel);
      cmd_pending.push_back(c);
   endtask

   // Reads one register and compares it with the shadow.
   task automatic csr_check(input logic [CSR_IDX_W-1:0] idx);
      logic [CSR_DATA_W-1:0] want;
      logic [CSR_DATA_W-1:0] got;
      case (idx)
         CSR_LED_COUNT: want = cfg_leds;
         CSR_GROUP:     want = cfg_group;
         default:       want = cfg_colours;
      endcase
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      got = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== want) begin
         mismatches++;
         if (mismatches <= SHOW_LIMIT)
            $display("%0t register %0d readback: expected %0d, got %0d",
                     $realtime, idx, want, got);
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         CSR_LED_COUNT: cfg_leds    = value & 32'hFFF;
         CSR_GROUP:     cfg_group   = value & 32'hFFF;
         default:       cfg_colours = value & 32'h7;
      endcase
      csr_check(idx);
   endtask

   // Waits until every command is transferred and every code has come out,
   // then lets the block settle on commands that produce nothing.
   task automatic wait_idle();
      do
         @(posedge clock);
      while (cmd_pending.size() != 0 || start || pulse_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random command for the current register setting: mostly renders of
   // channels on the strip, writes aimed at low store addresses half the time.
   task automatic add_random_cmd();
      int unsigned span;
      int          ch;
      span = cfg_leds * cfg_colours;
      if (span > 8192)
         span = 8192;
      if ($urandom_range(0, 99) < 35) begin
         add_cmd(OP_WRITE,
                 $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 511),
                 $urandom_range(0, 255), $urandom_range(0, 8191));
      end else begin
         if (span > 0 && $urandom_range(0, 7) != 0)
            ch = $urandom_range(0, span - 1);
         else
            ch = $urandom_range(0, 8191);
         add_cmd(OP_RENDER, $urandom_range(0, 511), $urandom_range(0, 255), ch);
      end
   endtask

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++)
         store_img[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset values of the registers
      csr_check(CSR_LED_COUNT);
      csr_check(CSR_GROUP);
      csr_check(CSR_COLOURS);

      // Directed: 8 LEDs, 3 colours. Extremes of the byte and of the store
      // address, each colour of the swap, last channel on the strip, channels
      // past the strip, ignored fields held at all ones.
      add_cmd(OP_WRITE,  0,   8'hFF, 8191);
      add_cmd(OP_WRITE,  1,   8'h00, 0);
      add_cmd(OP_WRITE,  2,   8'hA5, 0);
      add_cmd(OP_WRITE,  511, 8'h5A, 0);
      add_cmd(OP_WRITE,  23,  8'h81, 0);
      add_cmd(OP_RENDER, 511, 8'hFF, 0);
      add_cmd(OP_RENDER, 0,   0,     1);
      add_cmd(OP_RENDER, 0,   0,     2);
      add_cmd(OP_RENDER, 0,   0,     23);
      add_cmd(OP_RENDER, 0,   0,     24);
      add_cmd(OP_RENDER, 511, 8'hFF, 8191);
      add_cmd(OP_WRITE,  0,   8'h00, 0);
      add_cmd(OP_RENDER, 0,   0,     0);
      add_cmd(OP_RENDER, 0,   0,     22);
      wait_idle();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         csr_write(CSR_LED_COUNT, phase_leds[ph]);
         csr_write(CSR_GROUP,     phase_group[ph]);
         csr_write(CSR_COLOURS,   phase_colours[ph]);
         // one long stretch without request-side idling
         quiet_mode = (ph == 1);
         for (int n = 0; n < phase_cmds[ph]; n++)
            add_random_cmd();
         wait_idle();
      end

      if (mismatches == 0 && pulse_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[led_strip_pulse_encoder.f]
src/lspe_pkg.sv
src/lspe_div.sv
src/lspe_store.sv
src/led_strip_pulse_encoder.sv
test/led_strip_pulse_encoder_test.sv
